// ===== rtl/at_response_ipd_stream_parser_defines.svh =====
// Assertion macros shared by the stream parser modules.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef AT_RESPONSE_IPD_STREAM_PARSER_DEFINES_SVH
`define AT_RESPONSE_IPD_STREAM_PARSER_DEFINES_SVH

// Clocked property check, off while reset is held
`define APS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge
`define APS_ASSERT_NEVER(lbl, cond, msg) \
  `APS_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/aps_pkg.sv =====
// Package for the AT response stream parser: types, codes and text constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aps_pkg;

  // Depth of the command queue between front and back
  localparam int unsigned CMD_FIFO_DEPTH = 4;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Message prefix of a data frame
  localparam logic [0:3][7:0] PFX_IPD = "+IPD";

  // Line texts, padded with zero bytes to 15 characters
  localparam logic [0:14][7:0] TXT_CONNECT  = {",CONNECT", {7{8'h00}}};
  localparam logic [0:14][7:0] TXT_CLOSED   = {",CLOSED", {8{8'h00}}};
  localparam logic [0:14][7:0] TXT_FAIL     = {",CONNECT FAIL", {2{8'h00}}};
  localparam logic [0:14][7:0] TXT_WIFI_ON  = {"WIFI CONNECTED", 8'h00};
  localparam logic [0:14][7:0] TXT_WIFI_OFF = "WIFI DISCONNECT";

  // Result event kinds
  localparam logic [1:0] EV_PAYLOAD   = 2'd0;
  localparam logic [1:0] EV_CLEAR_ONE = 2'd1;
  localparam logic [1:0] EV_CLEAR_ALL = 2'd2;
  localparam logic [1:0] EV_LINE_END  = 2'd3;

  // Parser mode, one-hot
  typedef enum logic [3:0] {
    MODE_START   = 4'b0001,
    MODE_HEADER  = 4'b0010,
    MODE_PAYLOAD = 4'b0100,
    MODE_LINE    = 4'b1000
  } mode_e;

  // Commands from front to back
  typedef enum logic [1:0] {
    CMD_STORE    = 2'd0,
    CMD_LINE_END = 2'd1,
    CMD_PAYLOAD  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic       first;  // first byte of a message (line state restarts)
    logic       last;   // final payload byte of a frame
    logic [3:0] conn;
    logic [7:0] data;
  } cmd_t;

  // One byte step of an incremental text match. Text starts at line
  // position start and is tlen characters long.
  function automatic logic match_step(logic f, logic [7:0] ch, logic [6:0] pos,
                                      logic [6:0] start, logic [6:0] tlen,
                                      logic [0:14][7:0] txt);
    logic [6:0] rel;
    logic       hit;
    rel = pos - start;
    hit = f;
    if ((pos >= start) && (pos < (start + tlen))) begin
      hit = f && (ch == txt[rel[3:0]]);
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aps_cmd_fifo.sv =====
// Command queue between the parser front and the event back.
// Depends on aps_pkg (cmd_t) and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "at_response_ipd_stream_parser_defines.svh"

module aps_cmd_fifo import aps_pkg::*; #(
  parameter int unsigned DEPTH = CMD_FIFO_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  wire cmd_t wr_data_i,
  output logic      full_o,
  input  wire logic rd_i,
  output cmd_t      rd_data_o,
  output logic      rd_valid_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            wr_ok, rd_ok;

  assign full_o     = (count_q == CW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign wr_ok      = wr_i && !full_o;
  assign rd_ok      = rd_i && rd_valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_ok) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_ok) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_ok && !rd_ok) begin
      count_d = count_q + 1'b1;
    end else if (rd_ok && !wr_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `APS_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "queue count above depth")
  `APS_ASSERT(a_count_inc, (wr_ok && !rd_ok) |=> (count_q == $past(count_q) + 1'b1), "push lost")

endmodule

`default_nettype wire

// ===== rtl/aps_front.sv =====
// Parser front: tracks message mode, header fields and frame length, and turns
// each non-header byte into a command. Depends on aps_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "at_response_ipd_stream_parser_defines.svh"

module aps_front import aps_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            cmd_valid_o,
  output cmd_t            cmd_o
);

  mode_e       mode_q, mode_d;
  logic [7:0]  hdr_off_q, hdr_off_d;
  logic        prev_cr_q, prev_cr_d;
  logic [3:0]  frame_conn_q, frame_conn_d;
  logic [7:0]  frame_len_q, frame_len_d;
  logic [7:0]  payload_left_q, payload_left_d;
  logic [7:0]  digit;
  logic [7:0]  len_times10;

  assign digit       = rx_byte_i - CH_ZERO;
  assign len_times10 = {frame_len_q[4:0], 3'b000} + {frame_len_q[6:0], 1'b0};

  // Per byte mode update and command build
  always_comb begin
    mode_d         = mode_q;
    hdr_off_d      = hdr_off_q;
    prev_cr_d      = prev_cr_q;
    frame_conn_d   = frame_conn_q;
    frame_len_d    = frame_len_q;
    payload_left_d = payload_left_q;
    cmd_valid_o    = 1'b0;
    cmd_o.cmd      = CMD_STORE;
    cmd_o.first    = 1'b0;
    cmd_o.last     = 1'b0;
    cmd_o.conn     = frame_conn_q;
    cmd_o.data     = rx_byte_i;
    if (accept_i) begin
      case (mode_q)
        MODE_PAYLOAD: begin
          payload_left_d = payload_left_q - 1'b1;
          cmd_valid_o    = 1'b1;
          cmd_o.cmd      = CMD_PAYLOAD;
          cmd_o.last     = (payload_left_q == 8'd1);
          if (payload_left_q == 8'd1) begin
            mode_d    = MODE_START;
            hdr_off_d = '0;
            prev_cr_d = 1'b0;
          end
        end
        MODE_HEADER: begin
          if (hdr_off_q != 8'hFF) begin
            hdr_off_d = hdr_off_q + 1'b1;
          end
          if (hdr_off_q == 8'd5) begin
            frame_conn_d = digit[3:0];
          end else if (hdr_off_q == 8'd7) begin
            frame_len_d = digit;
          end else if (hdr_off_q >= 8'd8) begin
            if (rx_byte_i == CH_COLON) begin
              if (frame_len_q == '0) begin
                // empty frame: next byte opens a new message
                mode_d    = MODE_START;
                hdr_off_d = '0;
                prev_cr_d = 1'b0;
              end else begin
                payload_left_d = frame_len_q;
                mode_d         = MODE_PAYLOAD;
              end
            end else begin
              frame_len_d = len_times10 + digit;
            end
          end
        end
        MODE_START: begin
          cmd_valid_o = 1'b1;
          cmd_o.cmd   = CMD_STORE;
          cmd_o.first = (hdr_off_q == '0);
          if (rx_byte_i == PFX_IPD[hdr_off_q[1:0]]) begin
            hdr_off_d = hdr_off_q + 1'b1;
            if (hdr_off_q[1:0] == 2'd3) begin
              mode_d      = MODE_HEADER;
              frame_len_d = '0;
            end
          end else begin
            // prefix broken: the whole message is a line
            mode_d    = MODE_LINE;
            prev_cr_d = (rx_byte_i == CH_CR);
          end
        end
        MODE_LINE: begin
          cmd_valid_o = 1'b1;
          if (prev_cr_q && (rx_byte_i == CH_LF)) begin
            cmd_o.cmd = CMD_LINE_END;
            mode_d    = MODE_START;
            hdr_off_d = '0;
            prev_cr_d = 1'b0;
          end else begin
            cmd_o.cmd = CMD_STORE;
            prev_cr_d = (rx_byte_i == CH_CR);
          end
        end
        default: begin
          mode_d    = MODE_START;
          hdr_off_d = '0;
          prev_cr_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_START;
      hdr_off_q      <= '0;
      prev_cr_q      <= 1'b0;
      frame_conn_q   <= '0;
      frame_len_q    <= '0;
      payload_left_q <= '0;
    end else begin
      mode_q         <= mode_d;
      hdr_off_q      <= hdr_off_d;
      prev_cr_q      <= prev_cr_d;
      frame_conn_q   <= frame_conn_d;
      frame_len_q    <= frame_len_d;
      payload_left_q <= payload_left_d;
    end
  end

  `APS_ASSERT(a_payload_left, (mode_q == MODE_PAYLOAD) |-> (payload_left_q != '0), "payload count zero")
  `APS_ASSERT_NEVER(a_cr_in_header, (mode_q == MODE_HEADER) && prev_cr_q, "stale CR in header")

endmodule

`default_nettype wire

// ===== rtl/aps_back.sv =====
// Event back: follows line content with incremental text matches and
// builds result events into an output register. Depends on aps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aps_back import aps_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  input  wire cmd_t       cmd_i,
  output logic            cmd_take_o,
  output logic            empty_o,
  input  wire logic       pop_i,
  output logic [1:0]      event_kind_o,
  output logic [3:0]      conn_id_o,
  output logic [7:0]      payload_byte_o,
  output logic            frame_last_o
);

  logic [6:0] line_len_q, line_len_d;
  logic       digit_q, digit_d;
  logic [3:0] first_nib_q, first_nib_d;
  logic       m_conn_q, m_conn_d;
  logic       m_closed_q, m_closed_d;
  logic       m_fail_q, m_fail_d;
  logic       m_won_q, m_won_d;
  logic       m_woff_q, m_woff_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] kind_q, kind_d;
  logic [3:0] conn_q, conn_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;
  logic [6:0] pos;
  logic       hit_one, hit_all;

  assign cmd_take_o = cmd_valid_i && (!out_valid_q || pop_i);
  assign pos        = cmd_i.first ? 7'd0 : line_len_q;

  // Length checks of the line classes; line_len counts the trailing CR too
  assign hit_one = digit_q && ((m_conn_q && (line_len_q == 7'd10)) ||
                               (m_closed_q && (line_len_q == 7'd9)) ||
                               (m_fail_q && (line_len_q == 7'd15)));
  assign hit_all = (m_won_q && (line_len_q == 7'd15)) ||
                   (m_woff_q && (line_len_q == 7'd16));

  always_comb begin
    line_len_d  = line_len_q;
    digit_d     = digit_q;
    first_nib_d = first_nib_q;
    m_conn_d    = m_conn_q;
    m_closed_d  = m_closed_q;
    m_fail_d    = m_fail_q;
    m_won_d     = m_won_q;
    m_woff_d    = m_woff_q;
    out_valid_d = out_valid_q && !pop_i;
    kind_d      = kind_q;
    conn_d      = conn_q;
    data_d      = data_q;
    last_d      = last_q;
    if (cmd_take_o) begin
      case (cmd_i.cmd)
        CMD_STORE: begin
          if (cmd_i.first) begin
            line_len_d  = 7'd1;
            digit_d     = (cmd_i.data >= CH_ZERO) && (cmd_i.data <= CH_NINE);
            first_nib_d = cmd_i.data[3:0];
          end else if (line_len_q != 7'd127) begin
            line_len_d = line_len_q + 1'b1;
          end
          m_conn_d   = match_step(cmd_i.first || m_conn_q, cmd_i.data, pos,
                                  7'd1, 7'd8, TXT_CONNECT);
          m_closed_d = match_step(cmd_i.first || m_closed_q, cmd_i.data, pos,
                                  7'd1, 7'd7, TXT_CLOSED);
          m_fail_d   = match_step(cmd_i.first || m_fail_q, cmd_i.data, pos,
                                  7'd1, 7'd13, TXT_FAIL);
          m_won_d    = match_step(cmd_i.first || m_won_q, cmd_i.data, pos,
                                  7'd0, 7'd14, TXT_WIFI_ON);
          m_woff_d   = match_step(cmd_i.first || m_woff_q, cmd_i.data, pos,
                                  7'd0, 7'd15, TXT_WIFI_OFF);
        end
        CMD_LINE_END: begin
          // content shorter than two characters gives nothing
          if (line_len_q >= 7'd3) begin
            out_valid_d = 1'b1;
            data_d      = '0;
            last_d      = 1'b0;
            conn_d      = '0;
            if (hit_one) begin
              kind_d = EV_CLEAR_ONE;
              conn_d = first_nib_q;
            end else if (hit_all) begin
              kind_d = EV_CLEAR_ALL;
            end else begin
              kind_d = EV_LINE_END;
            end
          end
        end
        CMD_PAYLOAD: begin
          out_valid_d = 1'b1;
          kind_d      = EV_PAYLOAD;
          conn_d      = cmd_i.conn;
          data_d      = cmd_i.data;
          last_d      = cmd_i.last;
        end
        default: begin
          out_valid_d = out_valid_q && !pop_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q  <= '0;
      digit_q     <= 1'b0;
      m_conn_q    <= 1'b0;
      m_closed_q  <= 1'b0;
      m_fail_q    <= 1'b0;
      m_won_q     <= 1'b0;
      m_woff_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      line_len_q  <= line_len_d;
      digit_q     <= digit_d;
      m_conn_q    <= m_conn_d;
      m_closed_q  <= m_closed_d;
      m_fail_q    <= m_fail_d;
      m_won_q     <= m_won_d;
      m_woff_q    <= m_woff_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    first_nib_q <= first_nib_d;
    kind_q      <= kind_d;
    conn_q      <= conn_d;
    data_q      <= data_d;
    last_q      <= last_d;
  end

  assign empty_o        = !out_valid_q;
  assign event_kind_o   = kind_q;
  assign conn_id_o      = conn_q;
  assign payload_byte_o = data_q;
  assign frame_last_o   = last_q;

endmodule

`default_nettype wire

// ===== rtl/at_response_ipd_stream_parser.sv =====
// Top level of the AT response stream parser: front, command queue, back.
// Depends on aps_pkg, aps_front, aps_cmd_fifo and aps_back.
//
//   channel  | direction | handshake         | fields
//   ---------+-----------+-------------------+---------------------------------
//   rx byte  | in        | push / full       | rx_byte_i
//   event    | out       | empty / pop       | event_kind_o conn_id_o
//            |           |                   | payload_byte_o frame_last_o
//
// Takes one byte per cycle while full is low; the front updates its mode in
// the cycle a byte is accepted, so bytes can arrive back to back.
// A result goes into the command queue when its byte is accepted, then into
// the output register when the back takes it, and is popped from there.
// Reset clears all control state at once; there is no clearing pass.
// full rises when the FIFO_DEPTH-entry command queue is full; the back
// drains one command per cycle while its output register is free or popped.
`timescale 1ns / 1ps
`default_nettype none

module at_response_ipd_stream_parser import aps_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = CMD_FIFO_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      event_kind_o,
  output logic [3:0]      conn_id_o,
  output logic [7:0]      payload_byte_o,
  output logic            frame_last_o
);

  logic accept;
  logic f_cmd_valid;
  cmd_t f_cmd;
  logic q_full;
  cmd_t q_cmd;
  logic q_valid;
  logic b_take;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Byte classification
  aps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cmd_valid_o (f_cmd_valid),
    .cmd_o       (f_cmd)
  );

  // Decoupling queue
  aps_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (f_cmd_valid),
    .wr_data_i  (f_cmd),
    .full_o     (q_full),
    .rd_i       (b_take),
    .rd_data_o  (q_cmd),
    .rd_valid_o (q_valid)
  );

  // Line matching and event output
  aps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_cmd),
    .cmd_take_o     (b_take),
    .empty_o        (empty),
    .pop_i          (pop),
    .event_kind_o   (event_kind_o),
    .conn_id_o      (conn_id_o),
    .payload_byte_o (payload_byte_o),
    .frame_last_o   (frame_last_o)
  );

endmodule

`default_nettype wire

// ===== verif/aps_event_checker.sv =====
// Event checker for the AT response stream parser: tracks parser state from the
// accepted rx bytes, queues the events they cause and compares the popped ones.
// Depends on aps_pkg for characters, text constants, event kinds and modes.
`timescale 1ns / 1ps

module aps_event_checker import aps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] rx_byte_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [1:0] event_kind_i,
  input  logic [3:0] conn_id_i,
  input  logic [7:0] payload_byte_i,
  input  logic       frame_last_i,
  output int         outstanding_o,
  output int         fail_cnt_o
);

  // Only the first bytes of a line are kept for text matching
  localparam int unsigned LINE_BUF_LEN = 16;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] conn;
    logic [7:0] data;
    logic       last;
  } event_t;

  event_t     event_q[$];

  // Shadow parser state
  mode_e      mode_q;
  logic [7:0] hdr_off;
  logic       cr_seen;
  logic [3:0] frm_conn;
  logic [7:0] frm_len;
  logic [7:0] pay_left;
  logic [6:0] line_len;
  logic [7:0] line_buf [LINE_BUF_LEN];

  // Line content of length n equals txt placed at position start
  function automatic logic text_at(int unsigned n, int unsigned start, int unsigned tlen,
                                   logic [0:14][7:0] txt);
    if (n != start + tlen || n > LINE_BUF_LEN) return 1'b0;
    for (int unsigned i = 0; i < tlen; i++) begin
      if (line_buf[start + i] != txt[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic restart_message();
    mode_q   = MODE_START;
    hdr_off  = '0;
    cr_seen  = 1'b0;
    line_len = '0;
  endtask

  task automatic keep_char(input logic [7:0] ch);
    if (line_len < LINE_BUF_LEN) line_buf[line_len[3:0]] = ch;
    if (line_len != 7'd127) line_len = line_len + 7'd1;
  endtask

  // Advance the shadow parser by one byte; queue the event it causes, if any
  task automatic predict_event(input logic [7:0] ch);
    logic [7:0]  off;
    logic [7:0]  first;
    logic [7:0]  diff;
    int unsigned n;
    event_t      ev;
    ev = '0;
    diff = ch - CH_ZERO;
    if (mode_q == MODE_PAYLOAD) begin
      pay_left = pay_left - 8'd1;
      ev.kind = EV_PAYLOAD;
      ev.conn = frm_conn;
      ev.data = ch;
      ev.last = (pay_left == 8'd0);
      event_q.push_back(ev);
      if (pay_left == 8'd0) restart_message();
    end else if (mode_q == MODE_HEADER) begin
      off = hdr_off;
      if (hdr_off != 8'hFF) hdr_off = hdr_off + 8'd1;
      if (off == 8'd5) begin
        frm_conn = diff[3:0];
      end else if (off == 8'd7) begin
        frm_len = diff;
      end else if (off >= 8'd8) begin
        if (ch == CH_COLON) begin
          if (frm_len == 8'd0) begin
            restart_message();
          end else begin
            pay_left = frm_len;
            mode_q   = MODE_PAYLOAD;
          end
        end else begin
          frm_len = frm_len * 8'd10 + diff;
        end
      end
    end else begin
      // Prefix check; a mismatching byte falls through into line collection
      if (mode_q == MODE_START) begin
        if (ch == PFX_IPD[hdr_off[1:0]]) begin
          keep_char(ch);
          hdr_off = hdr_off + 8'd1;
          if (hdr_off >= 8'd4) begin
            mode_q  = MODE_HEADER;
            frm_len = '0;
          end
        end else begin
          mode_q = MODE_LINE;
        end
      end
      if (mode_q == MODE_LINE) begin
        if (cr_seen && ch == CH_LF) begin
          n     = int'(line_len) - 1;
          first = line_buf[0];
          diff  = first - CH_ZERO;
          restart_message();
          if (n >= 2) begin
            if (first >= CH_ZERO && first <= CH_NINE &&
                (text_at(n, 1, 8, TXT_CONNECT) || text_at(n, 1, 7, TXT_CLOSED) ||
                 text_at(n, 1, 13, TXT_FAIL))) begin
              ev.kind = EV_CLEAR_ONE;
              ev.conn = diff[3:0];
            end else if (text_at(n, 0, 14, TXT_WIFI_ON) ||
                         text_at(n, 0, 15, TXT_WIFI_OFF)) begin
              ev.kind = EV_CLEAR_ALL;
            end else begin
              ev.kind = EV_LINE_END;
            end
            event_q.push_back(ev);
          end
        end else begin
          keep_char(ch);
          cr_seen = (ch == CH_CR);
        end
      end
    end
  endtask

  // Predict on accepted bytes, compare on accepted events
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    event_t ev;
    int     errs;
    if (!rst_ni) begin
      event_q.delete();
      restart_message();
      frm_conn = '0;
      frm_len  = '0;
      pay_left = '0;
      for (int i = 0; i < LINE_BUF_LEN; i++) line_buf[i] = '0;
      outstanding_o <= 0;
      fail_cnt_o    <= 0;
    end else begin
      errs = 0;
      if (push_i && !full_i) predict_event(rx_byte_i);
      if (pop_i && !empty_i) begin
        if (event_q.size() == 0) begin
          $error("event with none expected: kind %0d conn %0d data %0h last %0d",
                 event_kind_i, conn_id_i, payload_byte_i, frame_last_i);
          errs++;
        end else begin
          ev = event_q.pop_front();
          if (event_kind_i !== ev.kind) begin
            $error("event_kind: expected %0d, got %0d", ev.kind, event_kind_i);
            errs++;
          end
          if (conn_id_i !== ev.conn) begin
            $error("conn_id: expected %0d, got %0d", ev.conn, conn_id_i);
            errs++;
          end
          if (payload_byte_i !== ev.data) begin
            $error("payload_byte: expected %0h, got %0h", ev.data, payload_byte_i);
            errs++;
          end
          if (frame_last_i !== ev.last) begin
            $error("frame_last: expected %0d, got %0d", ev.last, frame_last_i);
            errs++;
          end
        end
      end
      outstanding_o <= event_q.size();
      fail_cnt_o    <= fail_cnt_o + errs;
    end
  end

endmodule

// ===== verif/tb_at_response_ipd_stream_parser.sv =====
// Testbench top for the AT response stream parser: clock, reset, byte stream
// stimulus with bursty input and a stalling reader, watchdog and verdict.
// Depends on aps_pkg, the parser RTL and aps_event_checker.
`timescale 1ns / 1ps

module tb_at_response_ipd_stream_parser;
  import aps_pkg::*;

  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RANDOM_MSGS  = 8;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned END_CYCLES   = 10;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] rx_byte_i;
  logic       empty;
  logic       pop;
  logic [1:0] event_kind_o;
  logic [3:0] conn_id_o;
  logic [7:0] payload_byte_o;
  logic       frame_last_o;

  int          outstanding;
  int          fail_cnt;
  logic [7:0]  msg_q[$];
  int unsigned burst_left;
  int unsigned hold_req;
  int unsigned idle_cycles;
  bit          steady;

  at_response_ipd_stream_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte_i),
    .empty          (empty),
    .pop            (pop),
    .event_kind_o   (event_kind_o),
    .conn_id_o      (conn_id_o),
    .payload_byte_o (payload_byte_o),
    .frame_last_o   (frame_last_o)
  );

  aps_event_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .rx_byte_i      (rx_byte_i),
    .empty_i        (empty),
    .pop_i          (pop),
    .event_kind_i   (event_kind_o),
    .conn_id_i      (conn_id_o),
    .payload_byte_i (payload_byte_o),
    .frame_last_i   (frame_last_o),
    .outstanding_o  (outstanding),
    .fail_cnt_o     (fail_cnt)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Message building
  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  task automatic add_frame(input logic [7:0] id_ch, input int unsigned len,
                           input logic [7:0] sep_a, input logic [7:0] sep_b);
    add_str("+IPD");
    msg_q.push_back(sep_a);
    msg_q.push_back(id_ch);
    msg_q.push_back(sep_b);
    add_str($sformatf("%0d:", len));
    repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // One of the connection or wifi status lines, without CR LF
  task automatic add_known_line();
    int unsigned k;
    k = $urandom_range(0, 4);
    if (k < 3) begin
      msg_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
      case (k)
        0: add_str(",CONNECT");
        1: add_str(",CLOSED");
        default: add_str(",CONNECT FAIL");
      endcase
    end else if (k == 3) begin
      add_str("WIFI CONNECTED");
    end else begin
      add_str("WIFI DISCONNECT");
    end
  endtask

  // Offer one byte; idle gaps fall between bursts unless held steady
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0 && !steady) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_msg();
    while (msg_q.size() > 0) send_byte(msg_q.pop_front());
  endtask

  // Lower push and wait until every expected event has been popped
  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Reader: stall pattern changes per segment; long hold-off on request
  initial begin : reader
    int unsigned hold_seen;
    int unsigned seg;
    logic [15:0] pat;
    hold_seen = 0;
    seg       = 0;
    pat       = '1;
    pop       = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        if (seg == 0) begin
          seg = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0: pat = '1;
            1: pat = 16'($urandom) | 16'h0001;
            2: pat = 16'h0101;
            default: pat = 16'($urandom) | 16'h8421;
          endcase
        end
        seg--;
        pop <= pat[0];
        pat = {pat[0], pat[15:1]};
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: too long without any item moving on either side
  initial idle_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned k;
    int unsigned len;
    logic [7:0]  id_ch;
    push       = 1'b0;
    rx_byte_i  = '0;
    rst_ni     = 1'b0;
    burst_left = 0;
    steady     = 1'b0;
    hold_req   = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: frames, empty frame, odd header bytes, every line class
    add_frame("0", 3, ",", ",");
    add_frame("9", 1, ",", ",");
    add_str("+IPD,5,0:");
    add_str("+IPD,2,::");               // colon as first length digit: ten bytes
    msg_q.push_back(8'h00);
    msg_q.push_back(8'hFF);
    msg_q.push_back(CH_CR);
    msg_q.push_back(CH_LF);
    repeat (6) msg_q.push_back(8'($urandom_range(0, 255)));
    add_str("+IPD,3,;:");               // non-digit length byte
    repeat (11) msg_q.push_back(8'($urandom_range(0, 255)));
    add_frame("3", 2, "x", "y");        // separators are not checked
    add_frame("A", 1, "z", "q");        // id from a non-digit
    add_str("0,CONNECT\r\n1,CLOSED\r\n7,CONNECT FAIL\r\n");
    add_str("WIFI CONNECTED\r\nWIFI DISCONNECT\r\nOK\r\nA\r\n\r\n");
    add_str("X,CLOSED\r\n+IPX\r\n+I\r\n9,CONNECT FAIL!!\r\n");
    send_msg();
    drain();

    // Random messages, mostly well formed
    for (int unsigned m = 0; m < RANDOM_MSGS; m++) begin
      if (m == 1 || m == 6) begin
        // reader holds off while frame bytes keep coming
        hold_req++;
        steady = 1'b1;
        add_frame(8'h30 + 8'($urandom_range(0, 9)), 12, ",", ",");
        send_msg();
        steady = 1'b0;
      end
      if (m == 3 || m == 7) drain();
      if (m == 2) begin
        // header past the offset limit; colon lands beyond offset 255
        add_str("+IPD,4,1");
        repeat (249) add_str("0");
        add_str("3:");
        repeat (3) msg_q.push_back(8'($urandom_range(0, 255)));
        send_msg();
      end
      if (m == 5) begin
        // line past the length limit
        repeat (127) msg_q.push_back(8'($urandom_range(32, 126)));
        add_str("\r\n");
        send_msg();
      end

      r = $urandom_range(0, 99);
      if (r < 35) begin
        id_ch = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'h30 + 8'($urandom_range(0, 9));
        k = $urandom_range(0, 19);
        len = (k == 0) ? 0 : (k == 1) ? $urandom_range(25, 60) : $urandom_range(1, 12);
        if ($urandom_range(0, 4) == 0) begin
          add_frame(id_ch, len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else begin
          add_frame(id_ch, len, ",", ",");
        end
      end else if (r < 60) begin
        add_known_line();
        add_str("\r\n");
      end else if (r < 70) begin
        // near miss of a status line
        add_known_line();
        case ($urandom_range(0, 2))
          0: msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
          1: void'(msg_q.pop_back());
          default: msg_q.push_back(8'($urandom_range(32, 126)));
        endcase
        add_str("\r\n");
      end else if (r < 82) begin
        len = $urandom_range(0, 20);
        k = $urandom_range(0, 3);
        repeat (len) begin
          msg_q.push_back((k == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126)));
        end
        add_str("\r\n");
      end else if (r < 90) begin
        // broken frame prefix
        k = $urandom_range(1, 3);
        for (int unsigned i = 0; i < k; i++) msg_q.push_back(PFX_IPD[i]);
        msg_q.push_back(8'($urandom_range(0, 255)));
        add_str("\r\n");
      end else begin
        repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom_range(0, 255)));
        add_str("\r\n");
      end
      send_msg();
    end

    // Wait for the last events, then keep watching for stray ones before the verdict
    drain();
    repeat (END_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
